// ===== hw/rtl/multi_response_frame_checker_assert.svh =====
// Assertion macros for the multi-response frame checker.
// Each macro expects a signal named clk and a reset named rst in scope.
`ifndef MULTI_RESPONSE_FRAME_CHECKER_ASSERT_SVH
`define MULTI_RESPONSE_FRAME_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define MRFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mrfc assertion failed");
`define MRFC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mrfc assertion failed");
`else
`define MRFC_ASSERT(lbl, prop)
`define MRFC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/mrfc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the frame checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrfc_pkg;

  localparam int BUF_SIZE = 128;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd3;
  localparam logic [8:0] BUF_LIMIT = 9'(BUF_SIZE);

  // Register index of num_responses
  localparam logic REG_NUM_RESPONSES = 1'b0;
  localparam logic [7:0] NUM_RESPONSES_RESET = 8'd1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_DATA,
    PH_CRCH,
    PH_CRCL,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] frame_index;
    logic [6:0] start_offset;
    logic [7:0] frame_length;
    logic       checksum_good;
    logic       overrun;
    logic       last;
  } result_t;

  // Reflected CRC-16, one byte.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mrfc_parser.sv =====
// Frame parser: phase state machine, CRC accumulator and frame counters.
// Depends on mrfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrfc_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              first_byte,
  input  wire logic [7:0]        num_responses,
  output mrfc_pkg::result_t      result
);

  mrfc_pkg::phase_t phase, phase_next;
  logic [7:0]  frames_done, frames_done_next;
  logic [6:0]  frame_start, frame_start_next;
  logic [7:0]  frame_len, frame_len_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  crc_high, crc_high_next;

  logic [8:0] next_start;
  logic       ovr;
  logic       fin;

  assign next_start = {2'b00, frame_start} + {1'b0, frame_len} + mrfc_pkg::FRAME_OVERHEAD;
  assign ovr = next_start >= mrfc_pkg::BUF_LIMIT;
  assign fin = ovr || (({1'b0, frames_done} + 9'd1) >= {1'b0, num_responses});

  // Next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (first_byte) begin
        if (num_responses == 8'd0) begin
          phase_next = mrfc_pkg::PH_DONE;
        end else begin
          phase_next = (data_byte == 8'd0) ? mrfc_pkg::PH_CRCH : mrfc_pkg::PH_DATA;
        end
      end else begin
        case (phase)
          mrfc_pkg::PH_LEN: begin
            phase_next = (data_byte == 8'd0) ? mrfc_pkg::PH_CRCH : mrfc_pkg::PH_DATA;
          end
          mrfc_pkg::PH_DATA: begin
            if (bytes_left == 8'd1) phase_next = mrfc_pkg::PH_CRCH;
          end
          mrfc_pkg::PH_CRCH: phase_next = mrfc_pkg::PH_CRCL;
          mrfc_pkg::PH_CRCL: phase_next = fin ? mrfc_pkg::PH_DONE : mrfc_pkg::PH_LEN;
          default: phase_next = phase;
        endcase
      end
    end
  end

  // Datapath and result
  always_comb begin
    frames_done_next = frames_done;
    frame_start_next = frame_start;
    frame_len_next   = frame_len;
    bytes_left_next  = bytes_left;
    crc_acc_next     = crc_acc;
    crc_high_next    = crc_high;

    result               = '0;
    result.frame_index   = frames_done;
    result.start_offset  = frame_start;
    result.frame_length  = frame_len;
    result.checksum_good = (crc_acc == {crc_high, data_byte});
    result.overrun       = ovr;
    result.last          = fin;

    if (accept) begin
      if (first_byte) begin
        frames_done_next = 8'd0;
        frame_start_next = 7'd0;
        frame_len_next   = data_byte;
        bytes_left_next  = data_byte;
        crc_acc_next     = 16'h0000;
      end else begin
        case (phase)
          mrfc_pkg::PH_LEN: begin
            frame_len_next  = data_byte;
            bytes_left_next = data_byte;
            crc_acc_next    = 16'h0000;
          end
          mrfc_pkg::PH_DATA: begin
            crc_acc_next    = mrfc_pkg::crc16_update(crc_acc, data_byte);
            bytes_left_next = bytes_left - 8'd1;
          end
          mrfc_pkg::PH_CRCH: crc_high_next = data_byte;
          mrfc_pkg::PH_CRCL: begin
            result.valid     = 1'b1;
            frames_done_next = frames_done + 8'd1;
            // Only used when parsing continues, and then it lies below the buffer size
            frame_start_next = next_start[6:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mrfc_pkg::PH_IDLE;
      frames_done <= 8'd0;
      frame_start <= 7'd0;
      frame_len   <= 8'd0;
      bytes_left  <= 8'd0;
      crc_acc     <= 16'h0000;
      crc_high    <= 8'd0;
    end else begin
      phase       <= phase_next;
      frames_done <= frames_done_next;
      frame_start <= frame_start_next;
      frame_len   <= frame_len_next;
      bytes_left  <= bytes_left_next;
      crc_acc     <= crc_acc_next;
      crc_high    <= crc_high_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_response_frame_checker.sv =====
// A frame's result is registered when its last CRC byte is accepted: in the output
// register, or in the one-entry skid stage behind it if that register is stalled.
// Throughput: one byte per cycle while the input is not stalled; the CRC byte update
// and counters finish in that cycle. Input stalls only while the skid entry is full.
// Reset (rst, synchronous) idles the parser, empties both result slots, and sets
// num_responses to 1; bytes before the first marked byte are dropped.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_response_frame_checker_assert.svh"

module multi_response_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // byte stream in
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  // frame results out
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       frame_index,
  output logic [6:0]       start_offset,
  output logic [7:0]       frame_length,
  output logic             checksum_good,
  output logic             overrun,
  output logic             last
);

  logic [7:0] num_responses;
  logic       cfg_write;
  logic       reg_sel;

  logic              in_accept;
  mrfc_pkg::result_t res;
  mrfc_pkg::result_t out_reg;
  mrfc_pkg::result_t skid;
  logic              skid_valid;
  logic              out_open;

  // Configuration: single register, always ready
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[2] == mrfc_pkg::REG_NUM_RESPONSES) && (paddr[1:0] == 2'b00);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_sel ? {24'h000000, num_responses} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_responses <= mrfc_pkg::NUM_RESPONSES_RESET;
    end else if (cfg_write && reg_sel) begin
      num_responses <= pwdata[7:0];
    end
  end

  // Hold input while the skid entry is occupied; that is the only stall source.
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;

  mrfc_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .data_byte     (data_byte),
    .first_byte    (first_byte),
    .num_responses (num_responses),
    .result        (res)
  );

  // Output register advances when empty or taken; otherwise park a new result in skid.
  assign out_open = !out_reg.valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_open) begin
      if (skid_valid) begin
        out_reg.valid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        out_reg.valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end

    // Payload needs no reset
    if (out_open) begin
      if (skid_valid) begin
        out_reg.frame_index   <= skid.frame_index;
        out_reg.start_offset  <= skid.start_offset;
        out_reg.frame_length  <= skid.frame_length;
        out_reg.checksum_good <= skid.checksum_good;
        out_reg.overrun       <= skid.overrun;
        out_reg.last          <= skid.last;
      end else begin
        out_reg.frame_index   <= res.frame_index;
        out_reg.start_offset  <= res.start_offset;
        out_reg.frame_length  <= res.frame_length;
        out_reg.checksum_good <= res.checksum_good;
        out_reg.overrun       <= res.overrun;
        out_reg.last          <= res.last;
      end
    end
    if (!out_open && res.valid) begin
      skid <= res;
    end
  end

  assign out_valid     = out_reg.valid;
  assign frame_index   = out_reg.frame_index;
  assign start_offset  = out_reg.start_offset;
  assign frame_length  = out_reg.frame_length;
  assign checksum_good = out_reg.checksum_good;
  assign overrun       = out_reg.overrun;
  assign last          = out_reg.last;

  // Skid entry is only ever filled behind a full output register
  `MRFC_ASSERT(a_skid_behind_out, (skid_valid |-> out_reg.valid))
  // A parked result is not lost while output stays stalled
  `MRFC_ASSERT_NEXT(a_skid_holds, skid_valid && out_stall, skid_valid)
  // The parser only produces a result on an accepted byte
  `MRFC_ASSERT(a_result_on_accept, (res.valid |-> in_accept))

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_response_frame_checker: byte stream in, frame reports out.
// Depends on mrfc_pkg (phase enum, buffer size, register index) and the checker RTL.
// A scoreboard class predicts the reports; plain tasks drive bytes and APB writes.

module testbench;

  localparam int IDLE_LIMIT    = 3000;  // cycles with no transaction before giving up
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off to back up the block
  localparam int SETTLE_CYCLES = 8;     // drain time after the last report
  localparam int OFFSET_CAP    = 511;   // next-frame offset saturates here
  localparam int REPORT_LIMIT  = 10;    // mismatches shown in full
  localparam logic [2:0] NUM_RESPONSES_ADDR = 3'(4 * int'(mrfc_pkg::REG_NUM_RESPONSES));

  typedef struct packed {
    logic [7:0] index;
    logic [6:0] offset;
    logic [7:0] length;
    logic       crc_ok;
    logic       ovr;
    logic       fin;
  } frame_report_t;

  // Reflected CRC-16 over one byte, polynomial from the package.
  function automatic logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) begin
      if (r[0]) r = (r >> 1) ^ mrfc_pkg::CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  // Tracks the parser state, queues the report each closing CRC byte
  // should produce, and compares reports in order.
  class frame_report_board;
    logic [7:0]       responses;
    mrfc_pkg::phase_t phase;
    logic [8:0]       next_start;
    logic [7:0]       remaining;
    logic [15:0]      crc;
    logic [7:0]       crc_high;
    logic [7:0]       frames_seen;
    logic [7:0]       start;
    logic [7:0]       len;
    frame_report_t    due[$];
    int               errors;

    function new();
      responses   = mrfc_pkg::NUM_RESPONSES_RESET;
      phase       = mrfc_pkg::PH_IDLE;
      next_start  = '0;
      remaining   = '0;
      crc         = '0;
      crc_high    = '0;
      frames_seen = '0;
      start       = '0;
      len         = '0;
      errors      = 0;
    endfunction

    function void set_responses(logic [7:0] v);
      responses = v;
    endfunction

    function void open_frame(logic [7:0] b, logic [8:0] s);
      start     = s[7:0];
      len       = b;
      remaining = b;
      crc       = '0;
      phase     = (b == 8'd0) ? mrfc_pkg::PH_CRCH : mrfc_pkg::PH_DATA;
    endfunction

    function void note_byte(logic [7:0] b, logic f);
      int            nxt;
      logic          ovr;
      logic          fin;
      frame_report_t r;
      if (f) begin
        frames_seen = '0;
        next_start  = '0;
        if (responses == 8'd0) phase = mrfc_pkg::PH_DONE;
        else open_frame(b, 9'd0);
        return;
      end
      case (phase)
        mrfc_pkg::PH_LEN: begin
          open_frame(b, next_start);
        end
        mrfc_pkg::PH_DATA: begin
          crc       = crc_byte(crc, b);
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) phase = mrfc_pkg::PH_CRCH;
        end
        mrfc_pkg::PH_CRCH: begin
          crc_high = b;
          phase    = mrfc_pkg::PH_CRCL;
        end
        mrfc_pkg::PH_CRCL: begin
          nxt      = int'(start) + int'(len) + int'(mrfc_pkg::FRAME_OVERHEAD);
          ovr      = (nxt >= mrfc_pkg::BUF_SIZE);
          fin      = ovr || (int'(frames_seen) + 1 >= int'(responses));
          r.index  = frames_seen;
          r.offset = start[6:0];
          r.length = len;
          r.crc_ok = (crc == {crc_high, b});
          r.ovr    = ovr;
          r.fin    = fin;
          due.push_back(r);
          next_start  = 9'((nxt > OFFSET_CAP) ? OFFSET_CAP : nxt);
          frames_seen = frames_seen + 8'd1;
          phase       = fin ? mrfc_pkg::PH_DONE : mrfc_pkg::PH_LEN;
        end
        default: ;
      endcase
    endfunction

    function string show(frame_report_t r);
      return $sformatf("idx=%0d off=%0d len=%0d crc_ok=%0d overrun=%0d last=%0d",
                       r.index, r.offset, r.length, r.crc_ok, r.ovr, r.fin);
    endfunction

    function void check_result(frame_report_t got);
      frame_report_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("unexpected frame report: %s", show(got));
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("frame report mismatch: expected %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte  = '0;
  logic        first_byte = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [7:0]  frame_index;
  logic [6:0]  start_offset;
  logic [7:0]  frame_length;
  logic        checksum_good;
  logic        overrun;
  logic        last;

  frame_report_board sb;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit pressure_on = 1'b0;
  int hold_count  = 0;
  int idle_cycles = 0;
  int items_sent  = 0;

  always #1 clk = ~clk;

  multi_response_frame_checker DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .first_byte    (first_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_index   (frame_index),
    .start_offset  (start_offset),
    .frame_length  (frame_length),
    .checksum_good (checksum_good),
    .overrun       (overrun),
    .last          (last)
  );

  // Receiver: random stall, except for one long hold-off that this process
  // counts itself once pressure is switched on. The sender keeps offering
  // bytes meanwhile, so the result slots fill and the input stalls.
  always @(posedge clk) begin
    if (pressure_on && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Check every accepted report. Values read here are the ones from before
  // the edge, since all driving goes through nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(frame_report_t'{frame_index, start_offset, frame_length,
                                      checksum_good, overrun, last});
  end

  // Count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  // Offer one byte, with random idle cycles first; hold the payload until
  // the transaction completes, then feed it to the predictor.
  task automatic send_byte(input logic [7:0] b, input logic f);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    first_byte <= f;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, f);
    items_sent++;
  endtask

  // Drop valid, wait for every predicted report, then let the pipeline drain,
  // since bytes that produce no report may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of num_responses: setup cycle, then access until pready.
  task automatic write_responses(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_RESPONSES_ADDR;
    pwdata  <= {24'h000000, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_responses(v);
  endtask

  // Mostly short frames so several fit in a buffer; a few long ones overrun.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(0, 10);
    if (r < 95) return $urandom_range(11, 40);
    return $urandom_range(100, 255);
  endfunction

  // One complete frame: length, data, CRC high then low; optionally flip a CRC bit.
  task automatic send_frame(input bit opens, input int len, input bit corrupt);
    logic [15:0] acc;
    logic [7:0]  d;
    acc = 16'h0000;
    send_byte(8'(len), opens);
    for (int i = 0; i < len; i++) begin
      d   = 8'($urandom);
      acc = crc_byte(acc, d);
      send_byte(d, 1'b0);
    end
    if (corrupt) acc = acc ^ (16'h0001 << $urandom_range(15));
    send_byte(acc[15:8], 1'b0);
    send_byte(acc[7:0], 1'b0);
  endtask

  task automatic random_buffer(input int max_frames);
    int n;
    n = $urandom_range(1, max_frames);
    for (int k = 0; k < n; k++) send_frame(k == 0, pick_length(), $urandom_range(9) == 0);
  endtask

  // Zero to two good frames, then one cut off before its last CRC byte.
  task automatic broken_buffer();
    int full;
    int len;
    full = $urandom_range(0, 2);
    for (int k = 0; k < full; k++) send_frame(k == 0, pick_length(), 1'b0);
    len = $urandom_range(1, 12);
    send_byte(8'(len), full == 0);
    repeat ($urandom_range(0, len + 1)) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic run_mix(input int count, input int max_frames);
    int stop;
    int r;
    stop = items_sent + count;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if (r < 75) begin
        random_buffer(max_frames);
      end else if (r < 90) begin
        broken_buffer();
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(7) == 0);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 23;
    rx_idle_pct = 77;

    // Directed part, num_responses still at its reset value of one.
    // Bytes before any first byte are dropped.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // Zero-length frame: computed CRC is zero; it is also the last one.
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // Parsing has ended: this byte is ignored.
    send_byte(8'hA5, 1'b0);
    // One data byte of all ones with a bad CRC.
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();

    // Zero responses: a first byte ends parsing at once.
    write_responses(8'd0);
    send_byte(8'h03, 1'b1);
    send_byte(8'h55, 1'b0);
    settle();

    // Two responses; the first frame is abandoned by a new first byte mid-frame.
    write_responses(8'd2);
    send_byte(8'h02, 1'b1);
    send_byte(8'h01, 1'b0);
    send_frame(1'b1, 1, 1'b0);
    send_frame(1'b0, 0, 1'b0);
    settle();

    // Sender idles lightly, receiver stalls heavily.
    write_responses(8'd3);
    run_mix(600, 5);
    settle();

    // Maximum response count: buffers end by overrun or restart.
    write_responses(8'd255);
    tx_idle_pct = 77;
    rx_idle_pct = 23;
    run_mix(600, 12);
    settle();

    // No idling, starting with the long receiver hold-off.
    write_responses(8'd1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pressure_on = 1'b1;
    run_mix(300, 3);
    settle();

    write_responses(8'($urandom_range(4, 20)));
    run_mix(300, 8);

    // Wait for the last reports, then give the block time to show any extra one.
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
